// ===== design/fezc_pkg.sv =====
// shared types and constants for the frame energy and zero crossing block
`timescale 1ns / 1ps

package fezc_pkg;

    localparam int unsigned SUM_W   = 23;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned SQ_W    = 15;
    localparam int unsigned DIVD_W  = 17;
    localparam int unsigned AVG_W   = 15;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 9'd511;
    localparam logic [CNT_W-1:0] MIN_VALID   = 9'd10;
    localparam logic [7:0]       FLOOR_RESET = 8'd4;
    localparam logic [7:0]       ENERGY_MAX  = 8'd255;
    localparam logic [7:0]       SCALE       = 8'd255;

    typedef struct packed {
        logic [7:0] sample;
        logic       last_of_frame;
    } in_t;

    typedef struct packed {
        logic [7:0] energy;
        logic [7:0] crossing_rate;
    } out_t;

    // frame totals handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] square_sum;
        logic [CNT_W-1:0] crossing_count;
        logic [CNT_W-1:0] valid_pairs;
    } frame_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_DONE
    } back_state_t;

endpackage

// ===== design/frame_energy_zero_crossing.sv =====
// top level: short-time energy and zero crossing rate of framed audio
//
//  channel  handshake              payload
//  in       in_valid / in_ready    in_data  (sample, last_of_frame)
//  out      out_valid / out_ready  out_data (energy, crossing_rate)
//  cfg      cfg_valid / cfg_ready  cfg_data (noise floor, reset 4)
//
// one sample per cycle enters while the frame queue has room
// each frame result passes through the back end as load, 17 divide steps, hold
// frames that outpace the back end fill the queue and then stall in_ready
// reset clears the counters and queue, the noise floor returns to 4
// cfg_ready is always high; a stalled output does not stop the front until the queue fills
`timescale 1ns / 1ps

module frame_energy_zero_crossing #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  fezc_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output fezc_pkg::out_t out_data,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [7:0]     cfg_data
);
    import fezc_pkg::*;

    logic   q_full, q_push, q_pop, q_valid;
    frame_t push_data, pop_data;

    assign cfg_ready = 1'b1;

    fezc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    fezc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (pop_data)
    );

    fezc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== design/fezc_front.sv =====
// per-sample accumulation of energy and crossing counts
`timescale 1ns / 1ps

module fezc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  fezc_pkg::in_t   in_data,
    input  logic            cfg_valid,
    input  logic [7:0]      cfg_data,
    input  logic            q_full,
    output logic            q_push,
    output fezc_pkg::frame_t q_data
);
    import fezc_pkg::*;

    logic [7:0]       floor_reg;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [7:0]       prev_reg;
    logic             started_reg;
    logic [CNT_W-1:0] cross_reg, cross_next;
    logic [CNT_W-1:0] pairs_reg, pairs_next;

    logic             accept;
    logic             cur_neg, prev_neg;
    logic [7:0]       cur_mag, prev_mag;
    logic signed [7:0] cur_s;
    logic [SQ_W-1:0]  sq;
    logic [SUM_W:0]   sum_wide;
    logic             quiet;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign cur_neg  = !in_data.sample[7];
    assign prev_neg = !prev_reg[7];
    assign cur_mag  = cur_neg ? (8'd128 - in_data.sample) : (in_data.sample - 8'd128);
    assign prev_mag = prev_neg ? (8'd128 - prev_reg) : (prev_reg - 8'd128);
    assign cur_s    = signed'(in_data.sample ^ 8'h80);

    always_comb
    begin
        logic signed [15:0] prod;
        prod     = 16'(cur_s) * 16'(cur_s);
        sq       = prod[SQ_W-1:0];
        sum_wide = {1'b0, sum_reg} + {{(SUM_W+1-SQ_W){1'b0}}, sq};
        sum_next = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        quiet    = (cur_mag < floor_reg) && (prev_mag < floor_reg);
        pairs_next = pairs_reg;
        cross_next = cross_reg;
        if (started_reg && !quiet)
        begin
            if (pairs_reg != COUNT_MAX)
                pairs_next = pairs_reg + 1'b1;
            if ((cur_neg != prev_neg) && (cross_reg != COUNT_MAX))
                cross_next = cross_reg + 1'b1;
        end
    end

    assign q_push              = accept && in_data.last_of_frame;
    assign q_data.square_sum     = sum_next;
    assign q_data.crossing_count = cross_next;
    assign q_data.valid_pairs    = pairs_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg   <= FLOOR_RESET;
            sum_reg     <= '0;
            prev_reg    <= '0;
            started_reg <= 1'b0;
            cross_reg   <= '0;
            pairs_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
                floor_reg <= cfg_data;
            if (accept)
            begin
                if (in_data.last_of_frame)
                begin
                    sum_reg     <= '0;
                    prev_reg    <= '0;
                    started_reg <= 1'b0;
                    cross_reg   <= '0;
                    pairs_reg   <= '0;
                end
                else
                begin
                    sum_reg     <= sum_next;
                    prev_reg    <= in_data.sample;
                    started_reg <= 1'b1;
                    cross_reg   <= cross_next;
                    pairs_reg   <= pairs_next;
                end
            end
        end
    end

endmodule

// ===== design/fezc_queue.sv =====
// small fifo of frame totals between front and back
`timescale 1ns / 1ps

module fezc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fezc_pkg::frame_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output fezc_pkg::frame_t pop_data
);
    import fezc_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    frame_t          slots_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slots_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/fezc_back.sv =====
// frame-end scaling: energy multiply and bit-serial crossing rate divide
`timescale 1ns / 1ps

module fezc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  fezc_pkg::frame_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output fezc_pkg::out_t   out_data
);
    import fezc_pkg::*;

    localparam logic [4:0] LAST_STEP = 5'(DIVD_W - 1);

    back_state_t       state_reg, state_next;
    logic [7:0]        energy_reg;
    logic              zero_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [4:0]        step_reg;

    logic [AVG_W-1:0]  avg;
    logic [21:0]       scaled;
    logic [7:0]        energy_new;
    logic [DIVD_W-1:0] dividend;
    logic [CNT_W:0]    trial;
    logic              fits;
    logic              load;

    assign avg        = q_data.square_sum[SUM_W-1:8];
    assign scaled     = 22'(avg[13:0]) * 22'(SCALE);
    assign energy_new = avg[AVG_W-1] ? ENERGY_MAX : scaled[21:14];
    // crossing count times 255
    assign dividend   = {q_data.crossing_count, 8'd0}
                        - {{(DIVD_W-CNT_W){1'b0}}, q_data.crossing_count};

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:   if (q_valid) state_next = BK_DIVIDE;
            BK_DIVIDE: if (step_reg == LAST_STEP) state_next = BK_DONE;
            BK_DONE:   if (out_ready) state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            BK_IDLE:   q_pop = q_valid;
            BK_DIVIDE: ;
            BK_DONE:   out_valid = 1'b1;
            default:   ;
        endcase
    end

    assign load                   = q_pop;
    assign out_data.energy        = energy_reg;
    assign out_data.crossing_rate = zero_reg ? 8'd0 : quo_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                step_reg <= '0;
            else if (state_reg == BK_DIVIDE)
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            energy_reg <= energy_new;
            zero_reg   <= q_data.valid_pairs < MIN_VALID;
            div_reg    <= q_data.valid_pairs;
            rem_reg    <= '0;
            quo_reg    <= dividend;
        end
        else if (state_reg == BK_DIVIDE)
        begin
            rem_reg <= fits ? CNT_W'(trial - {1'b0, div_reg}) : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
        end
    end

endmodule

// ===== tb/tb_frame_energy_zero_crossing.sv =====
// testbench for the frame energy and zero crossing block
`timescale 1ns / 1ps

module tb_frame_energy_zero_crossing;
    import fezc_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned SUM_LIMIT    = (1 << SUM_W) - 1;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_t        in_data = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_t       out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    // predictor state
    logic [7:0]       floor_q;
    logic [SUM_W-1:0] square_acc;
    logic [7:0]       prev_sample_q;
    logic             in_frame;
    logic [CNT_W-1:0] crossings_q;
    logic [CNT_W-1:0] pairs_q;
    out_t             expected_features[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    frame_energy_zero_crossing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        out_t want;
        if (out_valid && out_ready)
        begin
            if (expected_features.size() == 0)
                report_mismatch($sformatf("unexpected result %p", out_data));
            else
            begin
                want = expected_features.pop_front();
                if (out_data.energy !== want.energy)
                    report_mismatch($sformatf("energy %0d, want %0d",
                                              out_data.energy, want.energy));
                if (out_data.crossing_rate !== want.crossing_rate)
                    report_mismatch($sformatf("crossing_rate %0d, want %0d",
                                              out_data.crossing_rate, want.crossing_rate));
            end
        end
    end

    function automatic void clear_frame_totals();
        square_acc    = '0;
        prev_sample_q = '0;
        in_frame      = 1'b0;
        crossings_q   = '0;
        pairs_q       = '0;
    endfunction

    // update the frame totals with one accepted sample, queue the features at frame end
    function automatic void accumulate_sample(input in_t item);
        int          cur;
        int          prev;
        int unsigned total;
        int unsigned avg;
        out_t        feat;
        cur   = int'(item.sample) - 128;
        total = int'(square_acc) + cur * cur;
        square_acc = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
        if (in_frame)
        begin
            prev = int'(prev_sample_q) - 128;
            if (!((cur < 0 ? -cur : cur) < int'(floor_q) &&
                  (prev < 0 ? -prev : prev) < int'(floor_q)))
            begin
                if (pairs_q < COUNT_MAX)
                    pairs_q++;
                // zero sits on the positive side
                if (((prev < 0) != (cur < 0)) && crossings_q < COUNT_MAX)
                    crossings_q++;
            end
        end
        prev_sample_q = item.sample;
        in_frame = 1'b1;
        if (item.last_of_frame)
        begin
            avg = square_acc / 256;
            feat.energy = (avg >= 16384) ? 8'd255 : 8'((avg * 255) / 16384);
            feat.crossing_rate = (pairs_q < MIN_VALID) ? 8'd0
                                 : 8'((int'(crossings_q) * 255) / int'(pairs_q));
            expected_features.push_back(feat);
            clear_frame_totals();
        end
    endfunction

    task automatic send_sample(input logic [7:0] sample, input logic last);
        in_t item;
        item.sample = sample;
        item.last_of_frame = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        accumulate_sample(item);
    endtask

    // mix of full-range, near-floor and sign-boundary samples
    function automatic logic [7:0] pick_sample();
        int amp;
        amp = (floor_q > 127) ? 127 : int'(floor_q);
        case ($urandom_range(4))
            0, 1:    return 8'($urandom_range(255));
            2:       return 8'($urandom_range(128 + amp, 128 - amp));
            3:
            begin
                case ($urandom_range(4))
                    0:       return 8'd0;
                    1:       return 8'd255;
                    2:       return 8'd127;
                    3:       return 8'd128;
                    default: return 8'd1;
                endcase
            end
            default: return 8'($urandom_range(131, 125));
        endcase
    endfunction

    task automatic send_frame(input int unsigned len);
        for (int unsigned i = 0; i < len; i++)
            send_sample(pick_sample(), i == len - 1);
    endtask

    // let every queued frame come out before touching the register
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_features.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_floor(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        floor_q = value;
    endtask

    task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
    endtask

    task automatic test_directed();
        logic [7:0] mixed[12] = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd128, 8'd0,
                                  8'd255, 8'd127, 8'd128, 8'd255, 8'd0, 8'd128};
        set_idling(0, 0);
        // single sample frame has no pairs
        send_sample(8'd0, 1'b1);
        for (int i = 0; i < 12; i++)
            send_sample(mixed[i], i == 11);
        // every pair below the reset floor
        for (int i = 0; i < 12; i++)
            send_sample((i % 2) ? 8'd130 : 8'd126, i == 11);
    endtask

    task automatic test_noise_floor();
        logic [7:0] floors[4] = '{8'd0, 8'd128, 8'd255, FLOOR_RESET};
        set_idling(33, 33);
        foreach (floors[i])
        begin
            drain();
            write_floor(floors[i]);
            send_frame(15);
            send_frame(11);
        end
    endtask

    task automatic test_oversized_frame();
        set_idling(0, 82);
        // full swing on every sample saturates the sum and both counters
        for (int i = 0; i < 560; i++)
            send_sample((i % 2) ? 8'd255 : 8'd0, i == 559);
    endtask

    task automatic test_random_frames();
        int unsigned idle_set[4]  = '{0, 82, 0, 33};
        int unsigned stall_set[4] = '{0, 0, 82, 33};
        int unsigned sent;
        int unsigned len;
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_floor((p == 0) ? 8'd4 : 8'($urandom_range(40)));
            set_idling(idle_set[p], stall_set[p]);
            sent = 0;
            while (sent < 250)
            begin
                case ($urandom_range(24))
                    0:       len = $urandom_range(300, 256);
                    1:       len = 1;
                    default: len = $urandom_range(40, 2);
                endcase
                send_frame(len);
                sent += len;
            end
        end
    endtask

    initial
    begin
        floor_q = FLOOR_RESET;
        clear_frame_totals();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_noise_floor();
        test_oversized_frame();
        test_random_frames();

        drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
